// ----- hdl/nadem_pkg.sv -----
`timescale 1ns / 1ps
package nadem_pkg;

   localparam int SINE_ITERATIONS = 20;
   localparam int ATAN_ENTRIES    = 30;
   localparam int CORDIC_STEPS    =
      (SINE_ITERATIONS < ATAN_ENTRIES) ? SINE_ITERATIONS : ATAN_ENTRIES;
   localparam int CORDIC_CNT_W    = $clog2(ATAN_ENTRIES);

   // serial multiplier: 33-bit signed multiplicand, 31-bit unsigned multiplier
   localparam int MUL_A_W   = 33;
   localparam int MUL_B_W   = 31;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W + 1;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);

   // range reduction: 32 remainder steps on x + 2^31
   localparam int RED_STEPS = 32;
   localparam int RED_CNT_W = $clog2(RED_STEPS);
   localparam int REM_W     = 24;

   localparam logic [REM_W-1:0]  TWO_PI_Q20     = 24'd6588397;
   localparam logic [REM_W-1:0]  OFFSET_MOD     = 24'd6254623; // 2^31 mod 2pi
   localparam logic signed [24:0] PI_Q20        = 25'sd3294199;
   localparam logic signed [24:0] HALF_PI_Q20   = 25'sd1647099;
   localparam logic signed [33:0] CORDIC_GAIN   = 34'sd652032874;

   localparam int ADDR_W = 5;

   typedef enum logic [2:0] {
      REG_DRIVE_A   = 3'd0,
      REG_STEP_H    = 3'd1,
      REG_SQRT_STEP = 3'd2,
      REG_INV_SQRT  = 3'd3,
      REG_INITIAL_X = 3'd4,
      REG_STEP_COUNT = 3'd5
   } reg_index_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_REDUCE = 5'b00010,
      ST_ROTATE = 5'b00100,
      ST_SCALE  = 5'b01000,
      ST_OUT    = 5'b10000
   } state_type;

   function automatic logic signed [33:0] atan_q30(input logic [CORDIC_CNT_W-1:0] i);
      logic signed [33:0] v;
      unique case (i)
         5'd0:  v = 34'sh3243F6A8;
         5'd1:  v = 34'sh1DAC6705;
         5'd2:  v = 34'sh0FADBAFC;
         5'd3:  v = 34'sh07F56EA6;
         5'd4:  v = 34'sh03FEAB76;
         5'd5:  v = 34'sh01FFD55B;
         5'd6:  v = 34'sh00FFFAAA;
         5'd7:  v = 34'sh007FFF55;
         5'd8:  v = 34'sh003FFFEA;
         5'd9:  v = 34'sh001FFFFD;
         5'd10: v = 34'sh00100000;
         5'd11: v = 34'sh00080000;
         5'd12: v = 34'sh00040000;
         5'd13: v = 34'sh00020000;
         5'd14: v = 34'sh00010000;
         5'd15: v = 34'sh00008000;
         5'd16: v = 34'sh00004000;
         5'd17: v = 34'sh00002000;
         5'd18: v = 34'sh00001000;
         5'd19: v = 34'sh00000800;
         5'd20: v = 34'sh00000400;
         5'd21: v = 34'sh00000200;
         5'd22: v = 34'sh00000100;
         5'd23: v = 34'sh00000080;
         5'd24: v = 34'sh00000040;
         5'd25: v = 34'sh00000020;
         5'd26: v = 34'sh00000010;
         5'd27: v = 34'sh00000008;
         5'd28: v = 34'sh00000004;
         5'd29: v = 34'sh00000002;
         default: v = 34'sh0;
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sh007FFFFFFF) r = 32'sh7FFFFFFF;
      else if (v < -40'sh0080000000) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

// ----- hdl/nadem_if.sv -----
`timescale 1ns / 1ps
interface nadem_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] noise_sample;
   modport source (output valid, output noise_sample, input ready);
   modport sink (input valid, input noise_sample, output ready);
endinterface

interface nadem_rsp_if;
   logic               valid;
   logic               ready;
   logic [19:0]        step_index;
   logic signed [31:0] x_before;
   logic signed [31:0] clean_slope;
   logic signed [31:0] x_after;
   logic signed [31:0] noisy_slope;
   logic               run_last;
   modport source (output valid, output step_index, output x_before, output clean_slope,
                   output x_after, output noisy_slope, output run_last, input ready);
   modport sink (input valid, input step_index, input x_before, input clean_slope,
                 input x_after, input noisy_slope, input run_last, output ready);
endinterface

// ----- hdl/nadem_mul.sv -----
`timescale 1ns / 1ps
module nadem_mul (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [nadem_pkg::MUL_A_W-1:0] mcand,
   input  logic [nadem_pkg::MUL_B_W-1:0]        mplier,
   output logic                                 done,
   output logic signed [nadem_pkg::MUL_P_W-1:0] product
);
   import nadem_pkg::*;

   logic signed [MUL_A_W:0]   hi_ff, hi_in;
   logic [MUL_B_W-1:0]        lo_ff, lo_in;
   logic signed [MUL_A_W-1:0] mcand_ff;
   logic [MUL_CNT_W-1:0]      cnt_ff, cnt_in;
   logic                      busy_ff, busy_in, done_ff, done_in;
   logic signed [MUL_A_W:0]   sum;

   // one multiplier bit per cycle, accumulate then shift right
   always_comb begin
      sum     = lo_ff[0] ? hi_ff + {mcand_ff[MUL_A_W-1], mcand_ff} : hi_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         hi_in   = '0;
         lo_in   = mplier;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in  = {sum[MUL_A_W], sum[MUL_A_W:1]};
         lo_in  = {sum[0], lo_ff[MUL_B_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CNT_W'(MUL_B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      cnt_ff <= cnt_in;
      if (start) mcand_ff <= mcand;
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};
endmodule

// ----- hdl/nadem_reduce.sv -----
`timescale 1ns / 1ps
module nadem_reduce (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] x,
   output logic               done,
   output logic signed [32:0] angle
);
   import nadem_pkg::*;

   logic [31:0]          shift_ff, shift_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [RED_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [REM_W-1:0]     trial;
   logic signed [24:0]   r0, r1, r2, r3;

   // restoring remainder of (x + 2^31) by 2pi, one bit per cycle
   always_comb begin
      trial    = {rem_ff[REM_W-2:0], shift_ff[31]};
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = {~x[31], x[30:0]};
         rem_in   = '0;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[30:0], 1'b0};
         rem_in   = (trial >= TWO_PI_Q20) ? trial - TWO_PI_Q20 : trial;
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == RED_CNT_W'(RED_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // undo the offset, then fold into [-pi/2, pi/2]
   always_comb begin
      r0 = $signed({1'b0, rem_ff}) - $signed({1'b0, OFFSET_MOD});
      r1 = (r0 < 0) ? r0 + $signed({1'b0, TWO_PI_Q20}) : r0;
      r2 = (r1 >= PI_Q20) ? r1 - $signed({1'b0, TWO_PI_Q20}) : r1;
      if (r2 > HALF_PI_Q20) r3 = PI_Q20 - r2;
      else if (r2 < -HALF_PI_Q20) r3 = -PI_Q20 - r2;
      else r3 = r2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
   end

   assign done  = done_ff;
   assign angle = {r3[22:0], 10'b0};
endmodule

// ----- hdl/nadem_cordic.sv -----
`timescale 1ns / 1ps
module nadem_cordic (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [32:0] angle,
   output logic               done,
   output logic signed [33:0] sine
);
   import nadem_pkg::*;

   logic signed [33:0]      cx_ff, cx_in, cy_ff, cy_in, z_ff, z_in;
   logic [CORDIC_CNT_W-1:0] i_ff, i_in;
   logic                    busy_ff, busy_in, done_ff, done_in;
   logic signed [33:0]      sx, sy, at;

   // one rotation per cycle
   always_comb begin
      sx      = cx_ff >>> i_ff;
      sy      = cy_ff >>> i_ff;
      at      = atan_q30(i_ff);
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      z_in    = z_ff;
      i_in    = i_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         cx_in   = CORDIC_GAIN;
         cy_in   = '0;
         z_in    = {angle[32], angle};
         i_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            cx_in = cx_ff - sy;
            cy_in = cy_ff + sx;
            z_in  = z_ff - at;
         end else begin
            cx_in = cx_ff + sy;
            cy_in = cy_ff - sx;
            z_in  = z_ff + at;
         end
         i_in = i_ff + 1'b1;
         if (i_ff == CORDIC_CNT_W'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      z_ff  <= z_in;
      i_ff  <= i_in;
   end

   assign done = done_ff;
   assign sine = cy_ff;
endmodule

// ----- hdl/noisy_adler_euler_maruyama_step.sv -----
`timescale 1ns / 1ps
// One Euler-Maruyama step of dx = (a - sin x)dt + dW per noise beat, Q12.20
// with saturation. A beat on req_chan carries the normal sample xi (Q4.12);
// one beat on rsp_chan returns step index, old x, a - sin x, new x and the
// noisy slope, with run_last on the final step of a run of step_count steps,
// after which x restarts from initial_x. A step runs the angle reduction, a
// bit-serial remainder, then the sine, 20 CORDIC rotations, then the drift
// product h*f, a shift-add multiply; the two noise products run alongside
// the reduction. Each step needs the x left by the last, so one step is in
// flight at a time, though the next noise beat is taken while a result beat
// still waits on rsp_chan. Registers on the APB port sit at 4*index; write
// them only while the block is idle.
module noisy_adler_euler_maruyama_step (
   input  logic                         clock,
   input  logic                         reset,
   nadem_req_if.sink                    req_chan,
   nadem_rsp_if.source                  rsp_chan,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [nadem_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);
   import nadem_pkg::*;

   // configuration registers
   logic signed [31:0] drive_a_ff, initial_x_ff;
   logic [19:0]        step_h_ff, sqrt_step_ff;
   logic [30:0]        inv_sqrt_ff;
   logic [20:0]        step_count_ff;
   logic               wr_en;
   reg_index_type      wr_idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign wr_idx = reg_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_a_ff    <= 32'sd1048576;
         step_h_ff     <= 20'd1049;
         sqrt_step_ff  <= 20'd33159;
         inv_sqrt_ff   <= 31'd33158909;
         initial_x_ff  <= '0;
         step_count_ff <= 21'd1000;
      end else if (wr_en) begin
         // unknown indexes are dropped
         unique case (wr_idx)
            REG_DRIVE_A:    drive_a_ff    <= pwdata;
            REG_STEP_H:     step_h_ff     <= pwdata[19:0];
            REG_SQRT_STEP:  sqrt_step_ff  <= pwdata[19:0];
            REG_INV_SQRT:   inv_sqrt_ff   <= pwdata[30:0];
            REG_INITIAL_X:  initial_x_ff  <= pwdata;
            REG_STEP_COUNT: step_count_ff <= pwdata[20:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (wr_idx)
         REG_DRIVE_A:    prdata = drive_a_ff;
         REG_STEP_H:     prdata = {12'b0, step_h_ff};
         REG_SQRT_STEP:  prdata = {12'b0, sqrt_step_ff};
         REG_INV_SQRT:   prdata = {1'b0, inv_sqrt_ff};
         REG_INITIAL_X:  prdata = initial_x_ff;
         REG_STEP_COUNT: prdata = {11'b0, step_count_ff};
         default:        prdata = '0;
      endcase
   end

   // sequencer and step state
   state_type          state_ff, state_in;
   logic signed [31:0] cur_x_ff, x_ff;
   logic [20:0]        counter_ff;
   logic signed [15:0] xi_ff;
   logic signed [31:0] f_ff, x_new_ff, noisy_ff;
   logic signed [39:0] noise_ff;
   logic               rsp_valid_ff;
   logic [19:0]        out_index_ff;
   logic signed [31:0] out_x_ff, out_f_ff, out_x_new_ff, out_noisy_ff;
   logic               out_last_ff;

   logic               req_fire, load_out, out_last;
   logic signed [31:0] x_sel;
   logic [21:0]        counter_next;

   logic               red_done, cordic_done, mula_done, mulb_done;
   logic signed [32:0] angle;
   logic signed [33:0] sine;
   logic               mula_start;
   logic signed [32:0] mula_a;
   logic [30:0]        mula_b;
   logic signed [64:0] mula_p, mulb_p;

   logic signed [39:0] sin_q20, f_wide, noise_now, drift, kick, x_sum, noisy_sum;
   logic signed [64:0] p_round_a, p_round_b, p_round_d;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign x_sel          = (counter_ff == '0) ? initial_x_ff : cur_x_ff;
   assign counter_next   = {1'b0, counter_ff} + 22'd1;
   assign out_last       = counter_next >= {1'b0, step_count_ff};
   assign load_out       = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   nadem_reduce u_reduce (
      .clock (clock),
      .reset (reset),
      .start (req_fire),
      .x     (x_sel),
      .done  (red_done),
      .angle (angle)
   );

   nadem_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (red_done && state_ff == ST_REDUCE),
      .angle  (angle),
      .done   (cordic_done),
      .sine   (sine)
   );

   // mul a: xi*sqrt(h) during reduction, then h*f once the sine is known
   assign mula_start = req_fire || (cordic_done && state_ff == ST_ROTATE);
   assign mula_a     = req_fire ? 33'(req_chan.noise_sample) : 33'(sat32(f_wide));
   assign mula_b     = req_fire ? {11'b0, sqrt_step_ff} : {11'b0, step_h_ff};

   nadem_mul u_mul_a (
      .clock   (clock),
      .reset   (reset),
      .start   (mula_start),
      .mcand   (mula_a),
      .mplier  (mula_b),
      .done    (mula_done),
      .product (mula_p)
   );

   // mul b: xi / sqrt(h) kick
   nadem_mul u_mul_b (
      .clock   (clock),
      .reset   (reset),
      .start   (req_fire),
      .mcand   (33'(req_chan.noise_sample)),
      .mplier  (inv_sqrt_ff),
      .done    (mulb_done),
      .product (mulb_p)
   );

   // round half up, then saturate
   always_comb begin
      sin_q20   = 40'((sine + 34'sd512) >>> 10);
      f_wide    = 40'(drive_a_ff) - sin_q20;
      p_round_a = (mula_p + 65'sd2048) >>> 12;
      noise_now = p_round_a[39:0];
      p_round_d = (mula_p + 65'sd524288) >>> 20;
      drift     = p_round_d[39:0];
      p_round_b = (mulb_p + 65'sd2048) >>> 12;
      kick      = p_round_b[39:0];
      x_sum     = 40'(x_ff) + drift + noise_ff;
      noisy_sum = 40'(f_ff) + kick;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_REDUCE;
         ST_REDUCE: if (red_done) state_in = ST_ROTATE;
         ST_ROTATE: if (cordic_done) state_in = ST_SCALE;
         ST_SCALE:  if (mula_done) state_in = ST_OUT;
         ST_OUT:    if (load_out) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
            counter_ff   <= out_last ? 21'd0 : counter_next[20:0];
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_fire) begin
         x_ff  <= x_sel;
         xi_ff <= req_chan.noise_sample;
      end
      if (cordic_done && state_ff == ST_ROTATE) begin
         f_ff     <= sat32(f_wide);
         noise_ff <= noise_now;
      end
      if (mula_done && state_ff == ST_SCALE) begin
         x_new_ff <= sat32(x_sum);
         noisy_ff <= sat32(noisy_sum);
      end
      if (load_out) begin
         out_index_ff <= counter_ff[19:0];
         out_x_ff     <= x_ff;
         out_f_ff     <= f_ff;
         out_x_new_ff <= x_new_ff;
         out_noisy_ff <= noisy_ff;
         out_last_ff  <= out_last;
         cur_x_ff     <= out_last ? initial_x_ff : x_new_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.step_index  = out_index_ff;
   assign rsp_chan.x_before    = out_x_ff;
   assign rsp_chan.clean_slope = out_f_ff;
   assign rsp_chan.x_after     = out_x_new_ff;
   assign rsp_chan.noisy_slope = out_noisy_ff;
   assign rsp_chan.run_last    = out_last_ff;

   // a result beat only comes out of the output state
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result beat raised outside output state");

   // end of a run clears the step counter
   a_run_restart: assert property (@(posedge clock) disable iff (reset)
      (load_out && out_last) |=> (counter_ff == '0))
      else $error("step counter not cleared at end of run");

   // sine finishes only while the sequencer waits on it
   a_cordic_phase: assert property (@(posedge clock) disable iff (reset)
      cordic_done |-> (state_ff == ST_ROTATE))
      else $error("cordic done outside rotate phase");

   // noise products are ready before the reduction hands over
   a_mul_b_early: assert property (@(posedge clock) disable iff (reset)
      mulb_done |-> (state_ff == ST_REDUCE))
      else $error("kick product finished out of phase");

   // xi is held for the whole step
   a_xi_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCALE) |-> $stable(xi_ff))
      else $error("noise sample changed mid step");
endmodule
